[rtl/core/nqbfs_pkg.sv]
// Shared constants and helper functions for the n-queens search core.
`timescale 1ns / 1ps

package nqbfs_pkg;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_SIDE       = 8;
   localparam int DEF_FRONTIER_DEPTH = 2048;

   // Fixed field widths
   localparam int SIDE_W  = 4;
   localparam int COUNT_W = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Bits needed to hold a column index on a board of max_side columns
   function automatic int col_width(input int max_side);
      int w;
      w = (max_side <= 1) ? 1 : $clog2(max_side);
      return w;
   endfunction

   // Bits needed to hold a queen count from 0 to max_side
   function automatic int depth_width(input int max_side);
      int w;
      w = $clog2(max_side + 1);
      return w;
   endfunction

   // Saturating increment of a result counter
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      r = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
      return r;
   endfunction

endpackage

[rtl/core/nqbfs_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module nqbfs_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[rtl/core/nqbfs_safe_check.sv]
// Attack test of one candidate square against the queens of a partial board.
`timescale 1ns / 1ps

module nqbfs_safe_check
   import nqbfs_pkg::*;
#(
   parameter int MAX_SIDE = DEF_MAX_SIDE
) (
   input  logic [depth_width(MAX_SIDE) + MAX_SIDE*col_width(MAX_SIDE)-1:0] board,
   input  logic [col_width(MAX_SIDE)-1:0]                                  cand_col,
   output logic                                                            safe
);

   localparam int COL_W = col_width(MAX_SIDE);
   localparam int DEP_W = depth_width(MAX_SIDE);
   localparam int SUM_W = DEP_W + 1;

   logic [DEP_W-1:0] row;
   logic [SUM_W-1:0] r_ext;
   logic [SUM_W-1:0] q_ext;
   logic [SUM_W-1:0] c_ext;
   logic [SUM_W-1:0] row_ext;
   logic             hit;

   assign row = board[DEP_W-1:0];

   // Compare the candidate with every placed queen in parallel
   always_comb begin
      hit     = 1'b0;
      c_ext   = SUM_W'(cand_col);
      row_ext = SUM_W'(row);
      r_ext   = '0;
      q_ext   = '0;
      for (int r = 0; r < MAX_SIDE; r++) begin
         r_ext = SUM_W'(r);
         q_ext = SUM_W'(board[DEP_W + r*COL_W +: COL_W]);
         if (r_ext < row_ext) begin
            if ((q_ext == c_ext) || (r_ext + q_ext == row_ext + c_ext) ||
                (r_ext + c_ext == row_ext + q_ext)) begin
               hit = 1'b1;
            end
         end
      end
      safe = ~hit;
   end

endmodule

[rtl/core/n_queens_breadth_first_search_core.sv]
// Top level of the n-queens breadth-first search core.
//
// Usage: send one board size on the req_ stream (rows in tdata[3:0],
// columns in tdata[7:4]; values above MAX_SIDE are clamped). The core runs a
// complete breadth-first search over a FIFO frontier held in one synchronous
// RAM and returns one transfer on the rsp_ stream with the solution count,
// the generated-state count (both saturating at 65535) and an overflow flag.
// Each popped frontier entry passes through a read state and a load state;
// an expanded entry then tests one column per cycle and closes the row once
// every column has been tried. An empty frontier ends the search through the
// done state. The RAM has one read port for pops and one write port for pushes.
// One search runs at a time.
// req_tready is high only while no search is running; a finished result sits
// in the rsp_ output register, so the next request is taken while the result
// still waits. If the receiver stalls, a finished search holds until the
// previous result has been taken. Reset clears control state and both
// handshakes; the frontier RAM needs no clearing pass, since every entry is
// written before it is read.
`timescale 1ns / 1ps

module n_queens_breadth_first_search_core
   import nqbfs_pkg::*;
#(
   parameter int MAX_SIDE       = DEF_MAX_SIDE,
   parameter int FRONTIER_DEPTH = DEF_FRONTIER_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [3:0] board_rows, [7:4] board_cols
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // rsp_tdata: [15:0] solution_count, [31:16] placed_state_count,
   //            [32] frontier_overflow, [39:33] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata
);

   localparam int COL_W   = col_width(MAX_SIDE);
   localparam int DEP_W   = depth_width(MAX_SIDE);
   localparam int ENTRY_W = DEP_W + MAX_SIDE*COL_W;
   localparam int PTR_W   = $clog2(FRONTIER_DEPTH);
   localparam int FILL_W  = $clog2(FRONTIER_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_LOAD,
      ST_EXPAND,
      ST_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [DEP_W-1:0]   rows_ff, rows_in;
   logic [DEP_W-1:0]   cols_ff, cols_in;
   logic [DEP_W-1:0]   col_ff, col_in;
   logic [ENTRY_W-1:0] cur_ff, cur_in;
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [COUNT_W-1:0] sol_ff, sol_in;
   logic [COUNT_W-1:0] gen_ff, gen_in;
   logic               ovf_ff, ovf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [39:0]        rsp_data_ff, rsp_data_in;

   logic               wr_en;
   logic [PTR_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [ENTRY_W-1:0] rd_data;
   logic [ENTRY_W-1:0] child;
   logic               cand_safe;
   logic [SIDE_W-1:0]  req_rows;
   logic [SIDE_W-1:0]  req_cols;
   logic [SIDE_W-1:0]  rows_clamp;
   logic [SIDE_W-1:0]  cols_clamp;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Clamp the requested board size
   assign req_rows   = req_tdata[3:0];
   assign req_cols   = req_tdata[7:4];
   assign rows_clamp = (req_rows > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : req_rows;
   assign cols_clamp = (req_cols > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : req_cols;

   // Frontier store
   nqbfs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (FRONTIER_DEPTH)
   ) u_frontier (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   // Attack test of the current column on the popped board
   nqbfs_safe_check #(
      .MAX_SIDE (MAX_SIDE)
   ) u_safe (
      .board    (cur_ff),
      .cand_col (col_ff[COL_W-1:0]),
      .safe     (cand_safe)
   );

   // Build the child board: add a queen at the current column
   always_comb begin
      child            = cur_ff;
      child[DEP_W-1:0] = cur_ff[DEP_W-1:0] + DEP_W'(1);
      for (int r = 0; r < MAX_SIDE; r++) begin
         if (cur_ff[DEP_W-1:0] == DEP_W'(r)) begin
            child[DEP_W + r*COL_W +: COL_W] = col_ff[COL_W-1:0];
         end
      end
   end

   // Next-state logic of the search sequencer
   always_comb begin
      state_in     = state_ff;
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      col_in       = col_ff;
      cur_in       = cur_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      sol_in       = sol_ff;
      gen_in       = gen_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_ff;
      wr_data      = child;
      rd_en        = 1'b0;

      // Drop the result once the receiver takes it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            // Start a search: push the empty root board
            if (req_tvalid) begin
               rows_in  = rows_clamp[DEP_W-1:0];
               cols_in  = cols_clamp[DEP_W-1:0];
               wr_en    = 1'b1;
               wr_addr  = '0;
               wr_data  = '0;
               head_in  = '0;
               tail_in  = PTR_W'(1);
               fill_in  = FILL_W'(1);
               sol_in   = '0;
               gen_in   = '0;
               ovf_in   = 1'b0;
               state_in = ST_POP;
            end
         end
         ST_POP: begin
            // Read the oldest board, or finish when the frontier is empty
            if (fill_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               head_in  = (head_ff == PTR_W'(FRONTIER_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
               fill_in  = fill_ff - FILL_W'(1);
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // Count a full board, otherwise start scanning its next row
            if (rd_data[DEP_W-1:0] >= rows_ff) begin
               sol_in   = sat_inc(sol_ff);
               state_in = ST_POP;
            end else begin
               cur_in   = rd_data;
               col_in   = '0;
               state_in = ST_EXPAND;
            end
         end
         ST_EXPAND: begin
            // Test one column per cycle, push each safe child
            if (col_ff == cols_ff) begin
               state_in = ST_POP;
            end else begin
               col_in = col_ff + DEP_W'(1);
               if (cand_safe) begin
                  if (fill_ff >= FILL_W'(FRONTIER_DEPTH)) begin
                     ovf_in   = 1'b1;
                     state_in = ST_DONE;
                  end else begin
                     wr_en   = 1'b1;
                     tail_in = (tail_ff == PTR_W'(FRONTIER_DEPTH - 1)) ?
                               '0 : tail_ff + PTR_W'(1);
                     fill_in = fill_ff + FILL_W'(1);
                     gen_in  = sat_inc(gen_ff);
                  end
               end
            end
         end
         ST_DONE: begin
            // Hand the counts to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0, ovf_ff, gen_ff, sol_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         sol_ff       <= '0;
         gen_ff       <= '0;
         ovf_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         sol_ff       <= sol_in;
         gen_ff       <= gen_in;
         ovf_ff       <= ovf_in;
      end
      rows_ff     <= rows_in;
      cols_ff     <= cols_in;
      col_ff      <= col_in;
      cur_ff      <= cur_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
